@@ design/lr_pkg.sv @@
// line rasterizer package: shared widths, register codes and control structs
// no dependencies
package lr_pkg;

  localparam int REG_W      = 12;
  localparam int ADDR_W     = 22;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [REG_W-1:0] WIDTH_RESET  = 12'd1024;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 12'd768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SURFACE_WIDTH  = 4'd0,
    CFG_SURFACE_HEIGHT = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [REG_W-1:0] width;
    logic [REG_W-1:0] height;
  } surface_t;

  // per-word control from the step engine to the output stage
  typedef struct packed {
    logic produce;
    logic done;
  } pix_ctl_t;

endpackage

@@ design/lr_ifs.sv @@
// handshake channel interfaces for the line rasterizer: input, result, config
// depends on lr_pkg
interface lr_in_if import lr_pkg::*; #(parameter int COORD_BITS = 12) ();
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [COLOR_W-1:0]           color;

  modport source (output valid, mode, x_start, y_start, x_end, y_end, color, input ready);
  modport sink   (input valid, mode, x_start, y_start, x_end, y_end, color, output ready);
endinterface

interface lr_out_if import lr_pkg::*; #(parameter int COORD_BITS = 12) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [ADDR_W-1:0]            pixel_addr;
  logic [COLOR_W-1:0]           pixel_color;
  logic                         write_enable;
  logic                         out_of_bounds;
  logic                         line_done;

  modport source (output valid, pixel_x, pixel_y, pixel_addr, pixel_color, write_enable,
                  out_of_bounds, line_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_addr, pixel_color, write_enable,
                  out_of_bounds, line_done, output ready);
endinterface

interface lr_cfg_if import lr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

@@ design/lr_cfg_regs.sv @@
// surface size registers written through the config channel
// depends on lr_pkg
module lr_cfg_regs import lr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_i,
  input  logic [CFG_IDX_W-1:0]  idx_i,
  input  logic [CFG_DATA_W-1:0] data_i,
  output surface_t              surf_o
);

  surface_t surf_q, surf_d;

  always_comb begin
    surf_d = surf_q;
    if (wr_i) begin
      case (idx_i)
        CFG_SURFACE_WIDTH:  surf_d.width  = data_i[REG_W-1:0];
        CFG_SURFACE_HEIGHT: surf_d.height = data_i[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surf_q.width  <= WIDTH_RESET;
      surf_q.height <= HEIGHT_RESET;
    end else begin
      surf_q <= surf_d;
    end
  end

  assign surf_o = surf_q;

endmodule

@@ design/lr_step_engine.sv @@
// line state and per-word stepping: major counter, error accumulator, current pixel
// depends on lr_pkg
module lr_step_engine import lr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  mode_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  input  logic [COLOR_W-1:0]    color_i,
  output logic [COORD_BITS-1:0] pix_x_o,
  output logic [COORD_BITS-1:0] pix_y_o,
  output logic [COLOR_W-1:0]    pix_color_o,
  output pix_ctl_t              ctl_o
);

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 1;

  logic          active_q, active_d;
  logic          x_major_q, x_major_d;
  logic          maj_neg_q, maj_neg_d;
  logic          min_neg_q, min_neg_d;
  logic [CB-1:0] big_q, big_d;
  logic [CB-1:0] small_q, small_d;
  logic [CB-1:0] off_q, off_d;
  logic [CB-1:0] err_q, err_d;
  logic          round_q, round_d;
  logic          par_q, par_d;
  logic [CB-1:0] cur_x_q, cur_x_d;
  logic [CB-1:0] cur_y_q, cur_y_d;
  logic [COLOR_W-1:0] color_q, color_d;

  // start decode
  logic [DW-1:0] dx, dy, dx_abs, dy_abs;
  logic [CB-1:0] adx, ady;
  logic          xm;

  // step arithmetic
  logic [CB-1:0] off_inc;
  logic          last;
  logic [CB:0]   err_sum, err_sub, twice;
  logic          carry, round_n, par_n, dq;
  logic [CB-1:0] err_n;
  logic [CB-1:0] maj_inc, min_inc;

  assign dx     = {x_end_i[CB-1], x_end_i} - {x_start_i[CB-1], x_start_i};
  assign dy     = {y_end_i[CB-1], y_end_i} - {y_start_i[CB-1], y_start_i};
  assign dx_abs = dx[DW-1] ? (~dx + DW'(1)) : dx;
  assign dy_abs = dy[DW-1] ? (~dy + DW'(1)) : dy;
  assign adx    = dx_abs[CB-1:0];
  assign ady    = dy_abs[CB-1:0];
  assign xm     = adx > ady;

  assign off_inc = off_q + CB'(1);
  assign last    = off_inc == big_q;

  // floor quotient and remainder of small*i/big, then round half to even
  assign err_sum = {1'b0, err_q} + {1'b0, small_q};
  assign carry   = err_sum >= {1'b0, big_q};
  assign err_sub = err_sum - {1'b0, big_q};
  assign err_n   = carry ? err_sub[CB-1:0] : err_sum[CB-1:0];
  assign par_n   = par_q ^ carry;
  assign twice   = {err_n, 1'b0};
  assign round_n = (twice > {1'b0, big_q}) || ((twice == {1'b0, big_q}) && par_n);
  // rounded minor offset moves by zero or one per step
  assign dq      = carry ^ round_n ^ round_q;

  assign maj_inc = maj_neg_q ? '1 : CB'(1);
  assign min_inc = dq ? (min_neg_q ? '1 : CB'(1)) : '0;

  always_comb begin
    active_d  = active_q;
    x_major_d = x_major_q;
    maj_neg_d = maj_neg_q;
    min_neg_d = min_neg_q;
    big_d     = big_q;
    small_d   = small_q;
    off_d     = off_q;
    err_d     = err_q;
    round_d   = round_q;
    par_d     = par_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    color_d   = color_q;
    ctl_o     = '{produce: 1'b0, done: 1'b1};

    if (!mode_i) begin
      x_major_d = xm;
      big_d     = xm ? adx : ady;
      small_d   = xm ? ady : adx;
      maj_neg_d = xm ? dx[DW-1] : dy[DW-1];
      min_neg_d = xm ? dy[DW-1] : dx[DW-1];
      off_d     = '0;
      err_d     = '0;
      round_d   = 1'b0;
      par_d     = 1'b0;
      cur_x_d   = x_start_i;
      cur_y_d   = y_start_i;
      color_d   = color_i;
      active_d  = (xm ? adx : ady) != '0;
      ctl_o     = '{produce: 1'b0, done: (xm ? adx : ady) == '0};
    end else if (active_q) begin
      ctl_o    = '{produce: 1'b1, done: last};
      off_d    = off_inc;
      err_d    = err_n;
      round_d  = round_n;
      par_d    = par_n;
      cur_x_d  = cur_x_q + (x_major_q ? maj_inc : min_inc);
      cur_y_d  = cur_y_q + (x_major_q ? min_inc : maj_inc);
      active_d = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (accept_i) begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      x_major_q <= x_major_d;
      maj_neg_q <= maj_neg_d;
      min_neg_q <= min_neg_d;
      big_q     <= big_d;
      small_q   <= small_d;
      off_q     <= off_d;
      err_q     <= err_d;
      round_q   <= round_d;
      par_q     <= par_d;
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      color_q   <= color_d;
    end
  end

  assign pix_x_o     = cur_x_q;
  assign pix_y_o     = cur_y_q;
  assign pix_color_o = color_q;

`ifndef NO_ASSERTIONS
  a_err_below_big: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (err_q < big_q))
    else $error("error accumulator not below major magnitude");

  a_off_below_big: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (off_q < big_q))
    else $error("major offset ran past line end");

  a_empty_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !mode_i && (x_end_i == x_start_i) && (y_end_i == y_start_i)) |=> !active_q)
    else $error("zero-length line left active");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && mode_i && active_q && last) |=> !active_q)
    else $error("line still active after its last pixel");
`endif

endmodule

@@ design/lr_pixel_out.sv @@
// clipping, linear address and the output register with its handshake
// depends on lr_pkg
module lr_pixel_out import lr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  out_ready_i,
  input  surface_t              surf_i,
  input  logic [COORD_BITS-1:0] pix_x_i,
  input  logic [COORD_BITS-1:0] pix_y_i,
  input  logic [COLOR_W-1:0]    pix_color_i,
  input  pix_ctl_t              ctl_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [ADDR_W-1:0]     pixel_addr_o,
  output logic [COLOR_W-1:0]    pixel_color_o,
  output logic                  write_enable_o,
  output logic                  out_of_bounds_o,
  output logic                  line_done_o
);

  localparam int CB   = COORD_BITS;
  localparam int CMPW = (CB > REG_W) ? CB : REG_W;
  localparam int PW   = CB + REG_W;

  logic            valid_q;
  logic            in_surf;
  logic [PW-1:0]   row_base;
  logic [ADDR_W-1:0] addr;

  logic [CB-1:0]      x_d, y_d;
  logic [ADDR_W-1:0]  addr_d;
  logic [COLOR_W-1:0] color_d;
  logic               we_d, oob_d;

  assign in_surf = !pix_x_i[CB-1] && !pix_y_i[CB-1] &&
                   (CMPW'(pix_x_i) < CMPW'(surf_i.width)) &&
                   (CMPW'(pix_y_i) < CMPW'(surf_i.height));

  // coordinates are non-negative whenever the address is used
  assign row_base = pix_y_i * surf_i.width;
  assign addr     = ADDR_W'(pix_x_i) + ADDR_W'(row_base);

  assign x_d     = ctl_i.produce ? pix_x_i : '0;
  assign y_d     = ctl_i.produce ? pix_y_i : '0;
  assign color_d = ctl_i.produce ? pix_color_i : '0;
  assign we_d    = ctl_i.produce && in_surf;
  assign oob_d   = ctl_i.produce && !in_surf;
  assign addr_d  = we_d ? addr : '0;

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pixel_x_o       <= x_d;
      pixel_y_o       <= y_d;
      pixel_addr_o    <= addr_d;
      pixel_color_o   <= color_d;
      write_enable_o  <= we_d;
      out_of_bounds_o <= oob_d;
      line_done_o     <= ctl_i.done;
    end
  end

  assign out_valid_o = valid_q;

endmodule

@@ design/line_rasterizer_top.sv @@
// line rasterizer top level: config registers, step engine, output stage
// depends on lr_pkg, lr_ifs, lr_cfg_regs, lr_step_engine, lr_pixel_out
//
//  channel | dir | word
//  --------+-----+-------------------------------------------------------------
//  in_i    | in  | mode, x_start, y_start, x_end, y_end, color
//  out_o   | out | pixel_x, pixel_y, pixel_addr, pixel_color, write_enable,
//          |     | out_of_bounds, line_done
//  cfg_i   | in  | idx, data (surface width and height, low 12 bits of data)
//
// one word in, one word out; a word can be taken every cycle while out_o is ready, result in the next cycle
// the rate is set by the line state registers: each step is one accumulator add and
// compare feeding the output register, where the clip and y*width address are formed
// rst_ni clears the line state to no active line and the surface to 1024 x 768
// in_i.ready drops only while a finished word sits in the output register unread
// cfg_i is always ready; a write lands at the same edge
module line_rasterizer_top import lr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lr_in_if.sink     in_i,
  lr_out_if.source  out_o,
  lr_cfg_if.sink    cfg_i
);

  surface_t surf;
  pix_ctl_t ctl;
  logic     in_ready;
  logic     accept;

  logic [COORD_BITS-1:0] pix_x, pix_y;
  logic [COLOR_W-1:0]    pix_color;

  // config port never stalls
  assign cfg_i.ready = 1'b1;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  lr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_i.valid),
    .idx_i  (cfg_i.idx),
    .data_i (cfg_i.data),
    .surf_o (surf)
  );

  // line state advances only on an accepted word
  lr_step_engine #(.COORD_BITS(COORD_BITS)) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (in_i.mode),
    .x_start_i   (in_i.x_start),
    .y_start_i   (in_i.y_start),
    .x_end_i     (in_i.x_end),
    .y_end_i     (in_i.y_end),
    .color_i     (in_i.color),
    .pix_x_o     (pix_x),
    .pix_y_o     (pix_y),
    .pix_color_o (pix_color),
    .ctl_o       (ctl)
  );

  // clip, address and result register
  lr_pixel_out #(.COORD_BITS(COORD_BITS)) u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .out_ready_i     (out_o.ready),
    .surf_i          (surf),
    .pix_x_i         (pix_x),
    .pix_y_i         (pix_y),
    .pix_color_i     (pix_color),
    .ctl_i           (ctl),
    .in_ready_o      (in_ready),
    .out_valid_o     (out_o.valid),
    .pixel_x_o       (out_o.pixel_x),
    .pixel_y_o       (out_o.pixel_y),
    .pixel_addr_o    (out_o.pixel_addr),
    .pixel_color_o   (out_o.pixel_color),
    .write_enable_o  (out_o.write_enable),
    .out_of_bounds_o (out_o.out_of_bounds),
    .line_done_o     (out_o.line_done)
  );

endmodule
